@@ design/ttrc_pkg.sv @@
// Package for the three-term recurrence checksum core.
// Holds the shared types, constants and small coefficient functions.
// No dependencies.
package ttrc_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] term_t;
    typedef logic [7:0]  index_t;

    // Recurrence constants.
    localparam byte_t  ALPHA_MULT  = 8'd17;
    localparam byte_t  BETA_MULT   = 8'd31;
    localparam term_t  SEED_OFFSET = 16'd7;
    localparam term_t  TERM_ONE    = 16'd1;
    localparam term_t  TERM_MOD    = 16'hFFFF;

    // Multiple of the modulus that is larger than any beta * term_prev.
    // It keeps the difference non-negative without changing its residue.
    localparam logic [24:0] DIFF_BIAS = 25'(65535 * 257);

    // Alpha coefficient: 17 * index, mod 256.
    function automatic byte_t alpha_of(input index_t idx);
        return byte_t'(idx * ALPHA_MULT);
    endfunction

    // Beta coefficient: 31 * index, mod 256.
    function automatic byte_t beta_of(input index_t idx);
        return byte_t'(idx * BETA_MULT);
    endfunction

endpackage

@@ design/ttrc_if.sv @@
// Handshake interfaces for the checksum core: the byte input channel and
// the checksum output channel. Depends on ttrc_pkg.
interface ttrc_in_if;
    import ttrc_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface ttrc_out_if;
    import ttrc_pkg::*;

    logic  valid;
    logic  ready;
    term_t checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

@@ design/three_term_recurrence_checksum_core.sv @@
// Top level of the three-term recurrence checksum core.
// Depends on ttrc_pkg, ttrc_if and ttrc_step.
//
//   Channel  Dir  Payload                      Transfer
//   in_ch    in   data_byte, end_of_message    valid && ready
//   out_ch   out  checksum                     valid && ready
//
// Each byte is held in the input register, where the recurrence step
// updates the terms; a final byte loads the checksum into the output register.
// One byte is accepted every cycle while no final byte is held back; the
// combinational step over two multipliers and the mod-65535 fold allows it.
// Reset puts the terms at one, the index at zero and empties both registers.
// A final byte waits in the input register only while an earlier checksum is
// still untaken.
module three_term_recurrence_checksum_core (
    input  logic        clk,
    input  logic        rst_n,
    ttrc_in_if.sink     in_ch,
    ttrc_out_if.source  out_ch
);
    import ttrc_pkg::*;

    logic   stage_valid_reg;
    byte_t  stage_byte_reg;
    logic   stage_last_reg;
    term_t  term_prev_reg;
    term_t  term_cur_reg;
    index_t byte_index_reg;
    logic   at_first_reg;
    logic   out_valid_reg;
    term_t  checksum_reg;

    logic   stall;
    logic   advance;
    term_t  step_term;
    term_t  new_term;

    // Flow control: only a final byte can be held back by the output.
    assign stall   = stage_valid_reg && stage_last_reg && out_valid_reg && !out_ch.ready;
    assign advance = stage_valid_reg && !stall;
    assign in_ch.ready = !stall;

    ttrc_step u_step (
        .data_byte  (stage_byte_reg),
        .byte_index (byte_index_reg),
        .term_cur   (term_cur_reg),
        .term_prev  (term_prev_reg),
        .next_term  (step_term)
    );

    // The first byte of a message seeds the recurrence.
    assign new_term = at_first_reg ? ({8'd0, stage_byte_reg} + SEED_OFFSET) : step_term;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            stage_byte_reg <= in_ch.data_byte;
            stage_last_reg <= in_ch.end_of_message;
        end
    end

    // Recurrence state; a final byte returns it to the reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_prev_reg  <= TERM_ONE;
            term_cur_reg   <= TERM_ONE;
            byte_index_reg <= '0;
            at_first_reg   <= 1'b1;
        end
        else if (advance)
        begin
            if (stage_last_reg)
            begin
                term_prev_reg  <= TERM_ONE;
                term_cur_reg   <= TERM_ONE;
                byte_index_reg <= '0;
                at_first_reg   <= 1'b1;
            end
            else
            begin
                term_prev_reg  <= at_first_reg ? TERM_ONE : term_cur_reg;
                term_cur_reg   <= new_term;
                byte_index_reg <= byte_index_reg + 8'd1;
                at_first_reg   <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && stage_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_last_reg)
        begin
            checksum_reg <= new_term;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.checksum = checksum_reg;

endmodule

@@ design/ttrc_step.sv @@
// One step of the recurrence: next term from a byte and the two stored terms.
// Purely combinational; depends on ttrc_pkg.
module ttrc_step (
    input  ttrc_pkg::byte_t  data_byte,
    input  ttrc_pkg::index_t byte_index,
    input  ttrc_pkg::term_t  term_cur,
    input  ttrc_pkg::term_t  term_prev,
    output ttrc_pkg::term_t  next_term
);
    import ttrc_pkg::*;

    logic [8:0]  factor_a;
    logic [24:0] prod_a;
    logic [23:0] prod_b;
    logic        diff_neg;
    logic [25:0] biased;
    logic [16:0] fold1;
    logic [15:0] fold2;

    // The two products of the recurrence, with operands widened to the full
    // product width so that no high bits are lost.
    assign factor_a = {1'b0, data_byte} + {1'b0, alpha_of(byte_index)};
    assign prod_a   = {16'd0, factor_a} * {9'd0, term_cur};
    assign prod_b   = {16'd0, beta_of(byte_index)} * {8'd0, term_prev};

    // A negative difference wraps in 64 bits, and 2^64 leaves residue one.
    assign diff_neg = {1'b0, prod_b} > prod_a;
    assign biased   = {1'b0, prod_a} + {1'b0, DIFF_BIAS} - {2'b00, prod_b}
                    + {25'd0, diff_neg};

    // Fold mod 65535: 2^16 is one, so high and low halves add.
    assign fold1 = {7'd0, biased[25:16]} + {1'b0, biased[15:0]};
    assign fold2 = fold1[15:0] + {15'd0, fold1[16]};
    assign next_term = (fold2 == TERM_MOD) ? '0 : fold2;

endmodule
